### hdl/fundamental_phasor_estimator_unit_assert.svh
// Assertion macros for the fundamental phasor estimator.
`ifndef FUNDAMENTAL_PHASOR_ESTIMATOR_UNIT_ASSERT_SVH
`define FUNDAMENTAL_PHASOR_ESTIMATOR_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FPE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FPE_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define FPE_ASSERT(label, clk, rst_n, prop, msg)
`define FPE_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

### hdl/fpe_pkg.sv
// Shared types, constants and tables of the fundamental phasor estimator.
package fpe_pkg;

  localparam int MaxChannels     = 8;
  localparam int MaxCycleSamples = 256;
  localparam int TwiddleDepth    = 1024;
  localparam int CordicSteps     = 30;
  localparam int ChW             = $clog2(MaxChannels);
  localparam int SumW            = 56;
  localparam int TwW             = 17;

  localparam logic [1:0] RegSamplesPerCycle = 2'd0;
  localparam logic [1:0] RegChannelsInUse   = 2'd1;
  localparam logic [1:0] RegWindowMode      = 2'd2;

  localparam logic ActSample = 1'b0;
  localparam logic ActClear  = 1'b1;

  localparam logic [39:0] MagMax      = 40'hFF_FFFF_FFFF;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [15:0] DegHalf = 16'sd23040;

  typedef struct packed {
    logic        action;
    logic [3:0]  channels_present;
    logic signed [31:0] sample_0;
    logic signed [31:0] sample_1;
    logic signed [31:0] sample_2;
    logic signed [31:0] sample_3;
    logic signed [31:0] sample_4;
    logic signed [31:0] sample_5;
    logic signed [31:0] sample_6;
    logic signed [31:0] sample_7;
    logic [63:0] timestamp;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  channel;
    logic [39:0] magnitude;
    logic signed [15:0] angle;
    logic [63:0] window_time;
    logic [31:0] window_count;
    logic        last;
  } out_req_t;

  function automatic logic [31:0] arc(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
      5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
      5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
      5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
      5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
      5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;       5'd21: r = 32'd326;
      5'd22: r = 32'd163;       5'd23: r = 32'd81;
      5'd24: r = 32'd41;        5'd25: r = 32'd20;
      5'd26: r = 32'd10;        5'd27: r = 32'd5;
      5'd28: r = 32'd3;         5'd29: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

### hdl/fundamental_phasor_estimator_unit.sv
// Top level of the fundamental phasor estimator.
// Usage: the input channel (in_valid_i, in_stall_o, in_req_i) carries one
// sample frame or a clear request. The output channel (out_valid_o,
// out_stall_i, out_req_o) delivers one phasor per channel in use when a
// window fills, channel 0 first, with last set on the final one.
// A sample request that does not close a window is finished before the
// next request is taken: a 20-step divide finds the twiddle index, a
// 30-step CORDIC makes the twiddle, then the lanes of the channels present
// multiply and accumulate side by side.
// A request that closes a window then runs the lanes in parallel through a
// square, a 57-step square root and, once the root is loaded, a 57-step
// divide, with the angle CORDIC running alongside; the results drain one
// per cycle while the receiver does not stall.
// A clear request gives no result.
// Configuration writes go through cfg_we_i, cfg_index_i and cfg_data_i.
// While the receiver stalls, the current result holds and no new request
// is taken. Reset restores the default registers and empties all sums.
module fundamental_phasor_estimator_unit import fpe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_req_t out_req_o,
  input  logic cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [8:0] cfg_data_i
);

`include "fundamental_phasor_estimator_unit_assert.svh"

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StTw    = 3'd1;
  localparam logic [2:0] StMac   = 3'd2;
  localparam logic [2:0] StConv  = 3'd3;
  localparam logic [2:0] StEmit  = 3'd4;
  localparam logic [2:0] StClear = 3'd5;

  logic [8:0] spc_q;
  logic [3:0] ciu_q;
  logic mode_q;
  logic [2:0] st_q;
  logic [8:0] pos_q;
  logic [63:0] time_q;
  logic [31:0] wdone_q;
  logic [3:0] mac_q;
  logic [ChW-1:0] emit_q;
  logic [MaxChannels-1:0] ldone_q;
  in_req_t req_q;
  logic [8:0] ncyc, win;
  logic [3:0] chans, nch;
  logic [9:0] idx;
  logic [31:0] ang;
  logic accept, clear_sums, tw_start, tw_done, acc, conv;
  logic signed [TwW-1:0] cosv, sinv;
  logic [MaxChannels-1:0] ldone;
  logic [39:0] mag [MaxChannels];
  logic signed [15:0] angv [MaxChannels];
  logic signed [31:0] smp [MaxChannels];
  logic cfg_clear;

  assign ncyc = (spc_q == 9'd0) ? 9'd1 : ((spc_q > 9'(MaxCycleSamples)) ? 9'(MaxCycleSamples) : spc_q);
  assign win = mode_q ? ncyc : (((ncyc >> 1) == 9'd0) ? 9'd1 : (ncyc >> 1));
  assign chans = (ciu_q > 4'(MaxChannels)) ? 4'(MaxChannels) : ciu_q;
  assign nch = (req_q.channels_present > chans) ? chans : req_q.channels_present;

  // Twiddle index round(pos*1024/N), pos below N so one step of the phase.
  logic [19:0] num;
  assign num = {1'b0, pos_q, 10'd0} + 20'(ncyc >> 1);
  logic [10:0] dq_q;
  logic [19:0] drem_q;
  logic [4:0] dcnt_q;

  assign idx = dq_q[9:0];
  assign ang = {idx, 22'd0};

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (st_q != StIdle);
  assign cfg_clear = cfg_we_i && (cfg_index_i == RegSamplesPerCycle ||
                     cfg_index_i == RegChannelsInUse || cfg_index_i == RegWindowMode);
  assign clear_sums = cfg_clear || (st_q == StClear);
  assign tw_start = (st_q == StTw) && (dcnt_q == 5'd1) && !clear_sums;
  assign acc = (st_q == StMac) && (mac_q == 4'd0);
  assign conv = (st_q == StConv) && (mac_q == 4'd0);

  assign smp[0] = req_q.sample_0; assign smp[1] = req_q.sample_1;
  assign smp[2] = req_q.sample_2; assign smp[3] = req_q.sample_3;
  assign smp[4] = req_q.sample_4; assign smp[5] = req_q.sample_5;
  assign smp[6] = req_q.sample_6; assign smp[7] = req_q.sample_7;

  fpe_twiddle u_tw (
    .clk_i, .rst_ni, .start_i(tw_start), .angle_i(ang),
    .done_o(tw_done), .cos_o(cosv), .sin_o(sinv)
  );

  for (genvar g = 0; g < MaxChannels; g++) begin : g_lane
    fpe_lane u_lane (
      .clk_i, .rst_ni, .clear_i(clear_sums), .acc_i(acc && (4'(g) < nch)),
      .sample_i(smp[g]), .cos_i(cosv), .sin_i(sinv), .conv_i(conv),
      .win_i(win), .done_o(ldone[g]), .mag_o(mag[g]), .ang_o(angv[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spc_q <= 9'd80;
      ciu_q <= 4'd8;
      mode_q <= 1'b1;
      st_q <= StIdle;
      pos_q <= '0;
      time_q <= '0;
      wdone_q <= '0;
      mac_q <= '0;
      emit_q <= '0;
      ldone_q <= '0;
      dcnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegSamplesPerCycle: begin
            spc_q <= cfg_data_i; pos_q <= '0; time_q <= '0; wdone_q <= '0;
          end
          RegChannelsInUse: begin
            ciu_q <= cfg_data_i[3:0]; pos_q <= '0; time_q <= '0; wdone_q <= '0;
          end
          RegWindowMode: begin
            mode_q <= cfg_data_i[0]; pos_q <= '0;
          end
          default: ;
        endcase
      end
      case (st_q)
        StIdle: begin
          if (accept) begin
            req_q <= in_req_i;
            if (in_req_i.action == ActClear) st_q <= StClear;
            else begin
              st_q <= StTw;
              dcnt_q <= 5'd21;
              drem_q <= '0;
              dq_q <= '0;
            end
          end
        end
        StTw: begin
          // Restoring divide of the phase numerator by N, one bit a cycle.
          if (dcnt_q > 5'd1) begin
            if ({drem_q[18:0], num[dcnt_q - 5'd2]} >= {11'd0, ncyc}) begin
              drem_q <= {drem_q[18:0], num[dcnt_q - 5'd2]} - {11'd0, ncyc};
              dq_q <= {dq_q[9:0], 1'b1};
            end else begin
              drem_q <= {drem_q[18:0], num[dcnt_q - 5'd2]};
              dq_q <= {dq_q[9:0], 1'b0};
            end
            dcnt_q <= dcnt_q - 5'd1;
          end else if (dcnt_q == 5'd1) begin
            dcnt_q <= 5'd0;
          end
          if (tw_done) begin
            st_q <= StMac;
            mac_q <= '0;
          end
        end
        StMac: begin
          mac_q <= mac_q + 4'd1;
          if (mac_q == 4'd2) begin
            time_q <= req_q.timestamp;
            if (pos_q + 9'd1 >= win) begin
              pos_q <= '0;
              wdone_q <= wdone_q + 32'd1;
              mac_q <= '0;
              st_q <= (chans == 4'd0) ? StIdle : StConv;
              ldone_q <= '0;
            end else begin
              pos_q <= pos_q + 9'd1;
              st_q <= StIdle;
            end
          end
        end
        StConv: begin
          mac_q <= 4'd1;
          ldone_q <= ldone_q | ldone;
          if (ldone_q[0]) begin
            st_q <= StEmit;
            emit_q <= '0;
          end
        end
        StEmit: begin
          if (!out_stall_i) begin
            if (4'(emit_q) + 4'd1 >= chans) st_q <= StIdle;
            else emit_q <= emit_q + ChW'(1);
          end
        end
        StClear: begin
          pos_q <= '0; time_q <= '0; wdone_q <= '0; st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o = (st_q == StEmit);
  always_comb begin
    out_req_o.channel = emit_q;
    out_req_o.magnitude = mag[emit_q];
    out_req_o.angle = angv[emit_q];
    out_req_o.window_time = time_q;
    out_req_o.window_count = wdone_q;
    out_req_o.last = (4'(emit_q) + 4'd1 == chans);
  end

  `FPE_ASSERT_NEVER(a_no_accept_busy, clk_i, rst_ni, accept && st_q != StIdle, "accept while busy")
  `FPE_ASSERT(a_emit_chan, clk_i, rst_ni, out_valid_o |-> (4'(emit_q) < chans), "channel beyond range")
  `FPE_ASSERT(a_pos_win, clk_i, rst_ni, (st_q == StIdle && !cfg_we_i) |-> (pos_q < win || pos_q == 9'd0), "position past window")

endmodule

### hdl/fpe_twiddle.sv
// Iterative rotation CORDIC that yields the Q1.15 cosine and sine of a phase.
module fpe_twiddle import fpe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic [31:0] angle_i,
  output logic done_o,
  output logic signed [TwW-1:0] cos_o,
  output logic signed [TwW-1:0] sin_o
);

  logic busy_q, busy_d;
  logic [4:0] step_q, step_d;
  logic [1:0] quad_q, quad_d;
  logic signed [33:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic signed [33:0] cx, sy, rc, rs;
  logic last_step;

  assign last_step = busy_q && (step_q == 5'(CordicSteps - 1));

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    quad_d = quad_q;
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      quad_d = angle_i[31:30];
      x_d = CordicGain;
      y_d = '0;
      z_d = {4'd0, angle_i[29:0]};
    end else if (busy_q) begin
      if (!z_q[33]) begin
        x_d = x_q - (y_q >>> step_q);
        y_d = y_q + (x_q >>> step_q);
        z_d = z_q - $signed({2'd0, arc(step_q)});
      end else begin
        x_d = x_q + (y_q >>> step_q);
        y_d = y_q - (x_q >>> step_q);
        z_d = z_q + $signed({2'd0, arc(step_q)});
      end
      step_d = step_q + 5'd1;
      if (last_step) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quad_q <= quad_d;
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  always_comb begin
    case (quad_q)
      2'd0: begin cx = x_q;  sy = y_q;  end
      2'd1: begin cx = -y_q; sy = x_q;  end
      2'd2: begin cx = -x_q; sy = -y_q; end
      default: begin cx = y_q; sy = -x_q; end
    endcase
    rc = (cx + 34'sd16384) >>> 15;
    rs = (sy + 34'sd16384) >>> 15;
  end

  assign cos_o = rc[TwW-1:0];
  assign sin_o = rs[TwW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else done_o <= last_step;
  end

endmodule

### hdl/fpe_lane.sv
// One channel lane: accumulates the bin-one sums and turns them into a phasor.
module fpe_lane import fpe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic clear_i,
  input  logic acc_i,
  input  logic signed [31:0] sample_i,
  input  logic signed [TwW-1:0] cos_i,
  input  logic signed [TwW-1:0] sin_i,
  input  logic conv_i,
  input  logic [8:0] win_i,
  output logic done_o,
  output logic [39:0] mag_o,
  output logic signed [15:0] ang_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSq   = 3'd1;
  localparam logic [2:0] StSqrt = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  logic signed [SumW-1:0] re_q, im_q;
  logic signed [48:0] pc_q, ps_q;
  logic pend_q;
  logic [2:0] st_q;
  logic [6:0] cnt_q;
  logic [55:0] ar_q, ai_q;
  logic [113:0] rad_q;
  logic [113:0] rem_q;
  logic [56:0] root_q;
  logic [56:0] quo_q;
  logic [14:0] dvs_q;
  logic [14:0] rdiv_q;
  logic signed [59:0] cx_q, cy_q;
  logic signed [33:0] cz_q;
  logic zero_q;
  logic [4:0] ci_q;
  logic [1:0] sq_ph_q;
  logic [113:0] rem_sh, trial;
  logic [15:0] rd_sh;
  logic [80:0] zprod;
  logic signed [80:0] zr;
  logic signed [47:0] dsel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      re_q <= '0;
      im_q <= '0;
      pend_q <= 1'b0;
    end else if (clear_i) begin
      re_q <= '0;
      im_q <= '0;
      pend_q <= 1'b0;
    end else begin
      pend_q <= acc_i;
      if (acc_i) begin
        pc_q <= sample_i * cos_i;
        ps_q <= sample_i * sin_i;
      end
      if (pend_q) begin
        re_q <= re_q + SumW'(pc_q);
        im_q <= im_q - SumW'(ps_q);
      end
      if (st_q == StSq) begin
        re_q <= '0;
        im_q <= '0;
      end
    end
  end

  assign rem_sh = {rem_q[111:0], rad_q[113:112]};
  assign trial  = {root_q, 2'b01};
  assign rd_sh  = {rdiv_q, quo_q[56]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      cnt_q <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      case (st_q)
        StIdle: begin
          if (conv_i) begin
            st_q <= StSq;
            ar_q <= re_q[SumW-1] ? 56'(-re_q) : 56'(re_q);
            ai_q <= im_q[SumW-1] ? 56'(-im_q) : 56'(im_q);
            zero_q <= (re_q == '0) && (im_q == '0);
            cx_q <= re_q[SumW-1] ? -60'(re_q) : 60'(re_q);
            cy_q <= re_q[SumW-1] ? -60'(im_q) : 60'(im_q);
            cz_q <= re_q[SumW-1] ? (im_q[SumW-1] ? -34'sh80000000 : 34'sh80000000) : '0;
            ci_q <= '0;
            dvs_q <= {win_i, 6'd0};
            sq_ph_q <= '0;
            rad_q <= '0;
          end
        end
        StSq: begin
          // Squares built from 28-bit halves: low, cross and high products in turn.
          case (sq_ph_q)
            2'd0: rad_q <= 114'(ar_q[27:0] * ar_q[27:0])
                         + 114'(ai_q[27:0] * ai_q[27:0]);
            2'd1: rad_q <= rad_q + (114'(ar_q[55:28] * ar_q[27:0]) << 29)
                         + (114'(ai_q[55:28] * ai_q[27:0]) << 29);
            default: rad_q <= rad_q + (114'(ar_q[55:28] * ar_q[55:28]) << 56)
                            + (114'(ai_q[55:28] * ai_q[55:28]) << 56);
          endcase
          sq_ph_q <= sq_ph_q + 2'd1;
          if (sq_ph_q == 2'd2) begin
            st_q <= StSqrt;
            cnt_q <= 7'd57;
            rem_q <= '0;
            root_q <= '0;
          end
        end
        StSqrt: begin
          if (rem_sh >= trial) begin
            rem_q <= rem_sh - trial;
            root_q <= {root_q[55:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            root_q <= {root_q[55:0], 1'b0};
          end
          rad_q <= {rad_q[111:0], 2'b00};
          cnt_q <= cnt_q - 7'd1;
          if (cnt_q == 7'd1) begin
            st_q <= StDiv;
            cnt_q <= 7'd57;
            rdiv_q <= '0;
          end
        end
        StDiv: begin
          quo_q <= (cnt_q == 7'd57) ? root_q : quo_q;
          if (cnt_q != 7'd57) begin
            if (rd_sh >= {1'b0, dvs_q}) begin
              rdiv_q <= 15'(rd_sh - {1'b0, dvs_q});
              quo_q <= {quo_q[55:0], 1'b1};
            end else begin
              rdiv_q <= rd_sh[14:0];
              quo_q <= {quo_q[55:0], 1'b0};
            end
          end
          cnt_q <= cnt_q - 7'd1;
          if (cnt_q == 7'd0) st_q <= StDone;
        end
        StDone: begin
          if (ci_q == 5'(CordicSteps - 1)) begin
            done_o <= 1'b1;
            st_q <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
      if (st_q != StIdle && ci_q != 5'(CordicSteps - 1)) begin
        if (!cy_q[59]) begin
          cx_q <= cx_q + (cy_q >>> ci_q);
          cy_q <= cy_q - (cx_q >>> ci_q);
          cz_q <= cz_q + $signed({2'd0, arc(ci_q)});
        end else begin
          cx_q <= cx_q - (cy_q >>> ci_q);
          cy_q <= cy_q + (cx_q >>> ci_q);
          cz_q <= cz_q - $signed({2'd0, arc(ci_q)});
        end
        ci_q <= ci_q + 5'd1;
      end
      if (st_q == StDone && ci_q == 5'(CordicSteps - 1)) begin
        if (!cy_q[59]) cz_q <= cz_q + $signed({2'd0, arc(ci_q)});
        else cz_q <= cz_q - $signed({2'd0, arc(ci_q)});
      end
    end
  end

  assign zprod = 81'($signed(cz_q) * $signed(81'sd46080)) + 81'sh80000000;
  assign zr = $signed(zprod) >>> 32;
  assign dsel = zr[47:0];

  always_comb begin
    mag_o = (quo_q > 57'(MagMax)) ? MagMax : quo_q[39:0];
    if (zero_q) ang_o = '0;
    else if (dsel <= -48'sd23040 || dsel > 48'sd23040) ang_o = DegHalf;
    else ang_o = dsel[15:0];
  end

endmodule
